@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk with active-low rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// when ante holds, cons must hold on the next clock edge
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/dmp_pkg.sv @@
// ----------------------------------------------------------------------------
// dmp_pkg
// shared constants and types for the debounced multi-press detector
// ----------------------------------------------------------------------------
package dmp_pkg;

    localparam int PRESS_COUNT = 3;
    localparam int SLOT_W      = (PRESS_COUNT > 1) ? $clog2(PRESS_COUNT) : 1;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW   = CFG_ADDR_W'(1);

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(50);
    localparam logic [CFG_W-1:0] WINDOW_RESET   = CFG_W'(3000);

    typedef struct packed {
        logic              press;
        logic [TIME_W-1:0] now;
    } press_evt_t;

    typedef struct packed {
        logic debounced_level;
        logic press_seen;
        logic multi_press;
    } result_t;

endpackage

@@ sv/dmp_debounce.sv @@
// ----------------------------------------------------------------------------
// dmp_debounce
// tick timer and debounce filter, flags debounced high-to-low edges
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmp_debounce
    import dmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             raw,
    input  logic [CFG_W-1:0] debounce_ticks,
    output press_evt_t       evt,
    output logic             level
);

    logic [TIME_W-1:0] tick_reg;
    logic [TIME_W-1:0] tick_next;
    logic              prev_raw_reg;
    logic [TIME_W-1:0] last_change_reg;
    logic [TIME_W-1:0] last_change_next;
    logic              stable_reg;
    logic              stable_next;
    logic [TIME_W-1:0] elapsed;
    logic              follow;

    always_comb
    begin
        elapsed          = tick_reg - last_change_reg;
        follow           = (raw == prev_raw_reg)
                           && (elapsed > TIME_W'(debounce_ticks))
                           && (raw != stable_reg);
        stable_next      = follow ? raw : stable_reg;
        last_change_next = (raw != prev_raw_reg) ? tick_reg : last_change_reg;
        tick_next        = tick_reg + TIME_W'(1);
        evt.press        = follow && !raw;
        evt.now          = tick_reg;
        level            = stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            prev_raw_reg    <= 1'b1;
            last_change_reg <= '0;
            stable_reg      <= 1'b1;
        end
        else if (step)
        begin
            tick_reg        <= tick_next;
            prev_raw_reg    <= raw;
            last_change_reg <= last_change_next;
            stable_reg      <= stable_next;
        end
    end

    `ASSERT_NEXT(a_hold_when_idle, !step, $stable(tick_reg) && $stable(stable_reg))
    `ASSERT_NEXT(a_change_stamp, step && (raw != prev_raw_reg),
                 last_change_reg == $past(tick_reg))
    `ASSERT_ALWAYS(a_press_is_fall, !evt.press || (stable_reg && !raw))

endmodule

@@ sv/dmp_press_window.sv @@
// ----------------------------------------------------------------------------
// dmp_press_window
// ring of press timestamps with parallel window age compares
// ----------------------------------------------------------------------------
module dmp_press_window
    import dmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  press_evt_t       evt,
    input  logic [CFG_W-1:0] window_ticks,
    output logic             multi
);

    logic [TIME_W-1:0]      times_reg [PRESS_COUNT];
    logic [PRESS_COUNT-1:0] valid_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic [PRESS_COUNT-1:0] hit;
    logic [TIME_W-1:0]      age [PRESS_COUNT];

    always_comb
    begin
        for (int i = 0; i < PRESS_COUNT; i++)
        begin
            age[i] = evt.now - times_reg[i];
            if (slot_reg == SLOT_W'(i))
                hit[i] = 1'b1;
            else
                hit[i] = valid_reg[i] && (age[i] <= TIME_W'(window_ticks));
        end
        multi     = evt.press && (&hit);
        slot_next = (slot_reg == SLOT_W'(PRESS_COUNT - 1)) ? '0 : slot_reg + SLOT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (step && evt.press)
            times_reg[slot_reg] <= evt.now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else if (step && evt.press)
        begin
            slot_reg <= slot_next;
            if (multi)
                valid_reg <= '0;
            else
                valid_reg[slot_reg] <= 1'b1;
        end
    end

endmodule

@@ sv/dmp_out_buf.sv @@
// ----------------------------------------------------------------------------
// dmp_out_buf
// two-entry result buffer, output register plus skid register
// ----------------------------------------------------------------------------
module dmp_out_buf
    import dmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_data,
    output logic    full
);

    logic    head_vld_reg;
    logic    skid_vld_reg;
    result_t head_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = head_vld_reg && !out_stall;
    assign out_valid = head_vld_reg;
    assign out_data  = head_reg;
    assign full      = skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (pop)
                skid_vld_reg <= 1'b0;
        end
        else if (head_vld_reg)
        begin
            if (push && !pop)
                skid_vld_reg <= 1'b1;
            else if (!push && pop)
                head_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            head_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (head_vld_reg)
        begin
            if (push && pop)
                head_reg <= push_data;
            else if (push)
                skid_reg <= push_data;
        end
        else if (push)
        begin
            head_reg <= push_data;
        end
    end

endmodule

@@ sv/debounced_multi_press_detector.sv @@
// ----------------------------------------------------------------------------
// debounced_multi_press_detector
// debounces an active-low button sampled once per tick and flags a burst
// of PRESS_COUNT presses inside a configurable window
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    button_level
//   out      output     out_valid/out_stall  debounced_level, press_seen,
//                                            multi_press
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall does not hold the flow;
// a result passes the input register, then the result register
// reset restores the register defaults, timer and press ring right away
// a stalled output fills the skid register, then in_stall rises
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module debounced_multi_press_detector
    import dmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  button_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  debounced_level,
    output logic                  press_seen,
    output logic                  multi_press,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic             in_vld_reg;
    logic             in_level_reg;
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] window_reg;
    logic             step;
    logic             buf_full;
    logic             level;
    logic             multi;
    press_evt_t       evt;
    result_t          res;
    result_t          out_res;

    assign cfg_ready = 1'b1;
    assign step      = in_vld_reg && !buf_full;
    assign in_stall  = in_vld_reg && buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            window_reg   <= WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_WINDOW:   window_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_level_reg <= button_level;
    end

    dmp_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .raw            (in_level_reg),
        .debounce_ticks (debounce_reg),
        .evt            (evt),
        .level          (level)
    );

    dmp_press_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .evt          (evt),
        .window_ticks (window_reg),
        .multi        (multi)
    );

    always_comb
    begin
        res.debounced_level = level;
        res.press_seen      = evt.press;
        res.multi_press     = multi;
    end

    dmp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_res),
        .full      (buf_full)
    );

    assign debounced_level = out_res.debounced_level;
    assign press_seen      = out_res.press_seen;
    assign multi_press     = out_res.multi_press;

    `ASSERT_ALWAYS(a_multi_needs_press, !out_valid || !multi_press || press_seen)
    `ASSERT_ALWAYS(a_press_level_low, !out_valid || !press_seen || !debounced_level)
    `ASSERT_ALWAYS(a_full_has_head, !buf_full || out_valid)

endmodule
